// ----- hw/rtl/rgb_to_hsi_pixel_top_assert.svh -----
// Assertion macros shared by the checker file of the HSI converter.
// Depends on nothing; include by bare file name.
`ifndef RGB_TO_HSI_PIXEL_TOP_ASSERT_SVH
`define RGB_TO_HSI_PIXEL_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define HSI_ASSERT_IMPL(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("hsi check failed");
// Next-cycle implication checked outside reset.
`define HSI_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("hsi check failed");
`endif

// ----- hw/rtl/rth_pkg.sv -----
// Package of the RGB to HSI converter: widths, CORDIC table, fixed constants.
// Depends on nothing.
`timescale 1ns / 1ps
package rth_pkg;
   localparam int CordicSteps = 18;
   localparam int AccWidth    = 30;   // x/y datapath, signed
   localparam int ZWidth      = 26;   // angle accumulator, signed
   localparam logic signed [ZWidth-1:0] HalfPiQ16  = 26'sd5898414;
   localparam logic signed [ZWidth-1:0] PiQ16      = 26'sd11796828;
   localparam logic signed [ZWidth-1:0] FullTurnQ16 = 26'sd23592960;
   localparam logic [16:0] Sqrt3Q16 = 17'd113512;

   function automatic logic signed [ZWidth-1:0] atan_tab(input logic [4:0] idx);
      logic signed [ZWidth-1:0] v;
      case (idx)
         5'd0: v = 26'sd2949207;
         5'd1: v = 26'sd1741019;
         5'd2: v = 26'sd919906;
         5'd3: v = 26'sd466959;
         5'd4: v = 26'sd234386;
         5'd5: v = 26'sd117307;
         5'd6: v = 26'sd58668;
         5'd7: v = 26'sd29336;
         5'd8: v = 26'sd14668;
         5'd9: v = 26'sd7334;
         5'd10: v = 26'sd3667;
         5'd11: v = 26'sd1834;
         5'd12: v = 26'sd917;
         5'd13: v = 26'sd458;
         5'd14: v = 26'sd229;
         5'd15: v = 26'sd115;
         5'd16: v = 26'sd57;
         5'd17: v = 26'sd29;
         default: v = '0;
      endcase
      return v;
   endfunction
endpackage

// ----- hw/rtl/rgb_to_hsi_pixel_top.sv -----
// Top level of the RGB to HSI pixel converter, a fully pipelined datapath.
// Depends on rth_pkg.
`timescale 1ns / 1ps
// Usage:
//  - req_ channel carries one RGB pixel per item (req_red/green/blue, 8 bits).
//  - rsp_ channel returns intensity, saturation percent and hue degrees.
//  - Pipeline: one setup stage, one CORDIC stage per iteration (18), and the
//    output register, fed by the hue clamp and mirror and the intensity
//    divide.
//  - Throughput is one item per clock while not stalled; no state links pixels.
//  - The saturation quotient is a short restoring divide spread one quotient
//    bit per CORDIC stage but the last, riding alongside the hue iterations.
//  - The whole pipe advances only when its last stage is empty or taken, so
//    a stalled receiver freezes every stage: nothing is lost or repeated.
//  - req_ready is high whenever the pipe can advance.
//  - Reset (synchronous, active high) clears every valid bit; payload
//    registers hold whatever they had and are ignored.
//  - Grey and black pixels give saturation 0 and hue 0.
module rgb_to_hsi_pixel_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_intensity,
   output logic [6:0] rsp_saturation_percent,
   output logic [8:0] rsp_hue_degrees
);
   localparam int N  = rth_pkg::CordicSteps;
   localparam int AW = rth_pkg::AccWidth;
   localparam int ZW = rth_pkg::ZWidth;

   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // Stage arrays: index k holds the item after k CORDIC iterations.
   logic                 vld_ff  [N+1];
   logic signed [AW-1:0] x_ff    [N+1];
   logic signed [AW-1:0] y_ff    [N+1];
   logic signed [ZW-1:0] z_ff    [N+1];
   logic [9:0]           sum_ff  [N+1];
   logic                 grey_ff [N+1];
   logic                 bgtg_ff [N+1];
   // Saturation divide: remainder and quotient of 100*(S-3M)/S.
   logic [9:0]           rem_ff  [N+1];
   logic [6:0]           quo_ff  [N+1];
   logic [16:0]          num_ff  [N+1];

   // Setup: reduce the inputs and pre-rotate into the right half plane.
   logic [9:0]           sum_in;
   logic [7:0]           min_in;
   logic [9:0]           diff_in;
   logic signed [AW-1:0] x0_in, y0_in, xr_in;
   logic signed [ZW-1:0] z0_in;
   logic [7:0]           dgb_in;
   logic [24:0]          yprod_in;

   always_comb begin
      sum_in = {2'b0, req_red} + {2'b0, req_green} + {2'b0, req_blue};
      min_in = req_red;
      if (req_green < min_in) min_in = req_green;
      if (req_blue < min_in) min_in = req_blue;
      diff_in = sum_in - (10'(min_in) * 10'd3);
      dgb_in = (req_green > req_blue) ? req_green - req_blue : req_blue - req_green;
      yprod_in = 25'(dgb_in) * 25'(rth_pkg::Sqrt3Q16);
      xr_in = AW'($signed({2'b0, req_red, 1'b0}) - $signed({3'b0, req_green})
                  - $signed({3'b0, req_blue})) <<< 16;
      if (xr_in < 0) begin
         x0_in = AW'($signed({1'b0, yprod_in}));
         y0_in = -xr_in;
         z0_in = rth_pkg::HalfPiQ16;
      end else begin
         x0_in = xr_in;
         y0_in = AW'($signed({1'b0, yprod_in}));
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
      end
      if (advance) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         sum_ff[0]  <= sum_in;
         grey_ff[0] <= (diff_in == '0);
         bgtg_ff[0] <= (req_blue > req_green);
         rem_ff[0]  <= '0;
         quo_ff[0]  <= '0;
         num_ff[0]  <= 17'(diff_in) * 17'd100;
      end
   end

   // CORDIC stages; all but the last also shift in one numerator bit of the divide.
   for (genvar k = 0; k < N; k++) begin : g_stage
      logic signed [AW-1:0] xs, ys, xn, yn;
      logic signed [ZW-1:0] zn;
      logic [10:0]          trial;
      logic [9:0]           rn;
      logic                 qb;
      logic [16:0]          numn;
      always_comb begin
         xs = x_ff[k] >>> k;
         ys = y_ff[k] >>> k;
         if (y_ff[k] > 0) begin
            xn = x_ff[k] + ys;
            yn = y_ff[k] - xs;
            zn = z_ff[k] + rth_pkg::atan_tab(5'(k));
         end else begin
            xn = x_ff[k] - ys;
            yn = y_ff[k] + xs;
            zn = z_ff[k] - rth_pkg::atan_tab(5'(k));
         end
         trial = {rem_ff[k], num_ff[k][16]};
         numn  = num_ff[k];
         rn    = rem_ff[k];
         qb    = 1'b0;
         // Numerator has 17 bits; the first 17 stages consume one bit each.
         if (k < 17) begin
            numn = {num_ff[k][15:0], 1'b0};
            if (trial >= {1'b0, sum_ff[k]}) begin
               rn = 10'(trial - {1'b0, sum_ff[k]});
               qb = 1'b1;
            end else begin
               rn = trial[9:0];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if (advance) begin
            x_ff[k+1]    <= xn;
            y_ff[k+1]    <= yn;
            z_ff[k+1]    <= zn;
            sum_ff[k+1]  <= sum_ff[k];
            grey_ff[k+1] <= grey_ff[k];
            bgtg_ff[k+1] <= bgtg_ff[k];
            rem_ff[k+1]  <= rn;
            quo_ff[k+1]  <= (k < 17) ? {quo_ff[k][5:0], qb} : quo_ff[k];
            num_ff[k+1]  <= numn;
         end
      end
   end

   // Finish: clamp, mirror, grey override; then the output register.
   logic signed [ZW-1:0] zc_in, zm_in;
   logic [7:0]           int_in;
   always_comb begin
      zc_in = z_ff[N];
      if (zc_in < 0) zc_in = '0;
      if (zc_in > rth_pkg::PiQ16) zc_in = rth_pkg::PiQ16;
      zm_in = bgtg_ff[N] ? rth_pkg::FullTurnQ16 - zc_in : zc_in;
      // Divide by 3 via reciprocal: floor(s*683/2048) is exact for s < 768.
      int_in = 8'((20'(sum_ff[N]) * 20'd683) >> 11);
   end

   logic       fin_vld_ff;
   logic [7:0] fin_int_ff;
   logic [6:0] fin_sat_ff;
   logic [8:0] fin_hue_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
      end else if (advance) begin
         fin_vld_ff <= vld_ff[N];
      end
      if (advance) begin
         fin_int_ff <= int_in;
         fin_sat_ff <= grey_ff[N] ? '0 : quo_ff[N];
         fin_hue_ff <= grey_ff[N] ? '0 : 9'(zm_in >>> 16);
      end
   end

   assign rsp_valid              = fin_vld_ff;
   assign rsp_intensity          = fin_int_ff;
   assign rsp_saturation_percent = fin_sat_ff;
   assign rsp_hue_degrees        = fin_hue_ff;
endmodule

// ----- hw/rtl/rth_checker.sv -----
// Port-level checker for the RGB to HSI converter, bound to the top level.
// Depends on rgb_to_hsi_pixel_top_assert.svh.
`timescale 1ns / 1ps
`include "rgb_to_hsi_pixel_top_assert.svh"
module rth_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_saturation_percent,
   input logic [8:0] rsp_hue_degrees
);
   // Hold the valid and the hue while stalled.
   `HSI_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hue_degrees))
   // Saturation never exceeds one hundred percent.
   `HSI_ASSERT_IMPL(a_sat, clock, reset, rsp_valid, rsp_saturation_percent <= 7'd100)
   // Hue stays within a full turn.
   `HSI_ASSERT_IMPL(a_hue, clock, reset, rsp_valid, rsp_hue_degrees <= 9'd360)
   // Hold the saturation too while stalled.
   `HSI_ASSERT_NEXT(a_sat_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_saturation_percent))
   // An empty output stage always lets a new item in.
   `HSI_ASSERT_IMPL(a_ready, clock, reset, !rsp_valid, req_ready)
endmodule

bind rgb_to_hsi_pixel_top rth_checker u_rth_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_saturation_percent(rsp_saturation_percent),
   .rsp_hue_degrees(rsp_hue_degrees)
);
